[design/urn_particle_move_on_graph_unit_macros.svh]
// assertion macros for the urn particle move on graph unit
// used by the top level only, no other dependencies
`ifndef URN_PARTICLE_MOVE_ON_GRAPH_UNIT_MACROS_SVH
`define URN_PARTICLE_MOVE_ON_GRAPH_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define URNPM_AST_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urnpm assertion failed");

// next-cycle implication, disabled while in reset
`define URNPM_AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urnpm assertion failed");

`endif

[design/urnpm_pkg.sv]
// shared types, codes and sizes of the urn particle move on graph unit
// no dependencies
`timescale 1ns / 1ps

package urnpm_pkg;

  // sizing
  localparam int MAX_NODES  = 64;
  localparam int COUNT_BITS = 16;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int NODE_W  = 6;
  localparam int ROW_W   = 64;
  localparam int PICK_W  = 31;
  localparam int CFG_W   = 7;
  localparam int STAT_W  = 3;
  localparam int OCNT_W  = 16;

  // derived sizes
  localparam int NODE_BITS  = $clog2(MAX_NODES);
  localparam int NCNT_BITS  = NODE_BITS + 1;
  localparam int PICK_IDX_W = $clog2(PICK_W);
  localparam int ALU_W      = (COUNT_BITS > NCNT_BITS) ? COUNT_BITS + 1 : NCNT_BITS + 1;

  // configuration port
  localparam int CFG_AW = 3;
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(MAX_NODES);

  // commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NO_NB = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_SAT   = 3'd4;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_SRC,
    S_GOT_SRC,
    S_ADD,
    S_POP,
    S_DIV,
    S_SEL,
    S_RD_DST,
    S_GOT_DST,
    S_DEC_SRC,
    S_INC_DST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [NODE_W-1:0] node;
    logic [ROW_W-1:0]  row_bits;
    logic [PICK_W-1:0] random_pick;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              moved;
    logic [NODE_W-1:0] destination;
    logic [OCNT_W-1:0] source_count;
    logic [OCNT_W-1:0] destination_count;
  } res_t;

  // low bits of a count, zero extended where the count is narrow
  function automatic logic [OCNT_W-1:0] fit_cnt(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[OCNT_W-1:0];
  endfunction

endpackage

[design/urnpm_ram.sv]
// generic single-port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module urnpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/urnpm_alu.sv]
// shared add / subtract unit with carry out
// depends on urnpm_pkg
`timescale 1ns / 1ps

module urnpm_alu (
  input  urnpm_pkg::alu_op_t              op,
  input  logic [urnpm_pkg::ALU_W-1:0]     a,
  input  logic [urnpm_pkg::ALU_W-1:0]     b,
  output logic [urnpm_pkg::ALU_W-1:0]     y,
  output logic                            borrow
);

  logic [urnpm_pkg::ALU_W:0] sum;

  always_comb begin
    unique case (op)
      urnpm_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
      urnpm_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
      default:            sum = '0;
    endcase
  end

  // top bit is carry on add, borrow on subtract
  assign y      = sum[urnpm_pkg::ALU_W-1:0];
  assign borrow = sum[urnpm_pkg::ALU_W];

endmodule

[design/urnpm_ctrl.sv]
// command sequencer with count and adjacency rams and the shared alu
// depends on urnpm_pkg, urnpm_ram, urnpm_alu
`timescale 1ns / 1ps

module urnpm_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  urnpm_pkg::cmd_t                cmd,
  input  logic [urnpm_pkg::CFG_W-1:0]    n_eff,
  output logic                           res_valid,
  input  logic                           res_ready,
  output urnpm_pkg::res_t                res
);

  localparam int NB = urnpm_pkg::NODE_BITS;
  localparam int CB = urnpm_pkg::COUNT_BITS;
  localparam int MN = urnpm_pkg::MAX_NODES;

  urnpm_pkg::state_t state_r, state_nxt;
  urnpm_pkg::cmd_t   cmd_r, cmd_nxt;
  urnpm_pkg::res_t   res_r, res_nxt;

  logic [CB-1:0]                       src_cnt_r, src_cnt_nxt;
  logic [CB-1:0]                       dst_cnt_r, dst_cnt_nxt;
  logic [MN-1:0]                       nb_r, nb_nxt;
  logic [NB-1:0]                       idx_r, idx_nxt;
  logic [urnpm_pkg::NCNT_BITS-1:0]     total_r, total_nxt;
  logic [NB-1:0]                       rem_r, rem_nxt;
  logic [urnpm_pkg::PICK_IDX_W-1:0]    bit_r, bit_nxt;
  logic [NB-1:0]                       seen_r, seen_nxt;
  logic [NB-1:0]                       chosen_r, chosen_nxt;
  logic [MN-1:0]                       adj_vld_r, adj_vld_nxt;
  logic [MN-1:0]                       cnt_vld_r, cnt_vld_nxt;

  logic                 adj_we;
  logic [NB-1:0]        adj_addr;
  logic [MN-1:0]        adj_wdata, adj_rdata, adj_row;
  logic                 cnt_we;
  logic [NB-1:0]        cnt_addr;
  logic [CB-1:0]        cnt_wdata, cnt_rdata;
  logic [CB-1:0]        src_val, dst_val;

  urnpm_pkg::alu_op_t              alu_op;
  logic [urnpm_pkg::ALU_W-1:0]     alu_a, alu_b, alu_y;
  logic                            alu_borrow;

  logic [NB-1:0]                   src;
  logic                            src_in_range;
  logic                            idx_last;
  logic [urnpm_pkg::NCNT_BITS-1:0] total_inc;
  logic [urnpm_pkg::NCNT_BITS-1:0] trial;

  urnpm_ram #(.WIDTH(MN), .DEPTH(MN)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .addr  (adj_addr),
    .wdata (adj_wdata),
    .rdata (adj_rdata)
  );

  urnpm_ram #(.WIDTH(CB), .DEPTH(MN)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  urnpm_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  assign src          = cmd_r.node[NB-1:0];
  assign src_in_range = urnpm_pkg::CFG_W'(cmd_r.node) < n_eff;
  assign idx_last     = urnpm_pkg::CFG_W'(idx_r) == (n_eff - urnpm_pkg::CFG_W'(1));
  assign total_inc    = total_r + urnpm_pkg::NCNT_BITS'(nb_r[idx_r]);
  assign trial        = {rem_r, cmd_r.random_pick[bit_r]};

  // entries never written read as zero
  assign adj_row = adj_vld_r[src] ? adj_rdata : '0;
  assign src_val = cnt_vld_r[src] ? cnt_rdata : '0;
  assign dst_val = cnt_vld_r[chosen_r] ? cnt_rdata : '0;

  assign cmd_ready = (state_r == urnpm_pkg::S_IDLE);
  assign res_valid = (state_r == urnpm_pkg::S_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= urnpm_pkg::S_IDLE;
      adj_vld_r <= '0;
      cnt_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      adj_vld_r <= adj_vld_nxt;
      cnt_vld_r <= cnt_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    res_r     <= res_nxt;
    src_cnt_r <= src_cnt_nxt;
    dst_cnt_r <= dst_cnt_nxt;
    nb_r      <= nb_nxt;
    idx_r     <= idx_nxt;
    total_r   <= total_nxt;
    rem_r     <= rem_nxt;
    bit_r     <= bit_nxt;
    seen_r    <= seen_nxt;
    chosen_r  <= chosen_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    res_nxt     = res_r;
    src_cnt_nxt = src_cnt_r;
    dst_cnt_nxt = dst_cnt_r;
    nb_nxt      = nb_r;
    idx_nxt     = idx_r;
    total_nxt   = total_r;
    rem_nxt     = rem_r;
    bit_nxt     = bit_r;
    seen_nxt    = seen_r;
    chosen_nxt  = chosen_r;
    adj_vld_nxt = adj_vld_r;
    cnt_vld_nxt = cnt_vld_r;

    adj_we    = 1'b0;
    adj_addr  = src;
    adj_wdata = cmd_r.row_bits[MN-1:0];
    cnt_we    = 1'b0;
    cnt_addr  = src;
    alu_op    = urnpm_pkg::ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    cnt_wdata = alu_y[CB-1:0];

    unique case (state_r)
      urnpm_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          state_nxt = urnpm_pkg::S_RD_SRC;
        end
      end

      urnpm_pkg::S_RD_SRC: begin
        res_nxt = '0;
        if (!src_in_range) begin
          res_nxt.status = urnpm_pkg::STAT_RANGE;
          state_nxt      = urnpm_pkg::S_DONE;
        end else begin
          if (cmd_r.command == urnpm_pkg::CMD_WRITE) begin
            adj_we           = 1'b1;
            adj_vld_nxt[src] = 1'b1;
          end
          state_nxt = urnpm_pkg::S_GOT_SRC;
        end
      end

      urnpm_pkg::S_GOT_SRC: begin
        src_cnt_nxt          = src_val;
        res_nxt.source_count = urnpm_pkg::fit_cnt(src_val);
        unique case (cmd_r.command)
          urnpm_pkg::CMD_ADD: state_nxt = urnpm_pkg::S_ADD;
          urnpm_pkg::CMD_MOVE: begin
            if (src_val == '0) begin
              res_nxt.status = urnpm_pkg::STAT_EMPTY;
              state_nxt      = urnpm_pkg::S_DONE;
            end else begin
              nb_nxt    = adj_row;
              idx_nxt   = '0;
              total_nxt = '0;
              state_nxt = urnpm_pkg::S_POP;
            end
          end
          default: state_nxt = urnpm_pkg::S_DONE;
        endcase
      end

      urnpm_pkg::S_ADD: begin
        if (src_cnt_r == urnpm_pkg::CNT_MAX) begin
          res_nxt.status = urnpm_pkg::STAT_SAT;
        end else begin
          alu_op               = urnpm_pkg::ALU_ADD;
          alu_a                = urnpm_pkg::ALU_W'(src_cnt_r);
          alu_b                = urnpm_pkg::ALU_W'(1);
          cnt_we               = 1'b1;
          cnt_vld_nxt[src]     = 1'b1;
          res_nxt.source_count = urnpm_pkg::fit_cnt(alu_y[CB-1:0]);
        end
        state_nxt = urnpm_pkg::S_DONE;
      end

      // neighbor count, one row bit a cycle
      urnpm_pkg::S_POP: begin
        total_nxt = total_inc;
        idx_nxt   = idx_r + NB'(1);
        if (idx_last) begin
          if (total_inc == '0) begin
            res_nxt.status = urnpm_pkg::STAT_NO_NB;
            state_nxt      = urnpm_pkg::S_DONE;
          end else begin
            rem_nxt   = '0;
            bit_nxt   = urnpm_pkg::PICK_IDX_W'(urnpm_pkg::PICK_W - 1);
            state_nxt = urnpm_pkg::S_DIV;
          end
        end
      end

      // restoring remainder, one pick bit a cycle, msb first
      urnpm_pkg::S_DIV: begin
        alu_op = urnpm_pkg::ALU_SUB;
        alu_a  = urnpm_pkg::ALU_W'(trial);
        alu_b  = urnpm_pkg::ALU_W'(total_r);
        if (!alu_borrow) begin
          rem_nxt = alu_y[NB-1:0];
        end else begin
          rem_nxt = trial[NB-1:0];
        end
        if (bit_r == '0) begin
          idx_nxt   = '0;
          seen_nxt  = '0;
          state_nxt = urnpm_pkg::S_SEL;
        end else begin
          bit_nxt = bit_r - urnpm_pkg::PICK_IDX_W'(1);
        end
      end

      // walk the row for the k-th set bit
      urnpm_pkg::S_SEL: begin
        idx_nxt = idx_r + NB'(1);
        if (nb_r[idx_r]) begin
          if (seen_r == rem_r) begin
            chosen_nxt = idx_r;
            state_nxt  = urnpm_pkg::S_RD_DST;
          end else begin
            seen_nxt = seen_r + NB'(1);
          end
        end
      end

      urnpm_pkg::S_RD_DST: begin
        if (chosen_r == src) begin
          // self loop, counts unchanged
          res_nxt.moved             = 1'b1;
          res_nxt.destination       = urnpm_pkg::NODE_W'(chosen_r);
          res_nxt.destination_count = urnpm_pkg::fit_cnt(src_cnt_r);
          state_nxt                 = urnpm_pkg::S_DONE;
        end else begin
          cnt_addr  = chosen_r;
          state_nxt = urnpm_pkg::S_GOT_DST;
        end
      end

      urnpm_pkg::S_GOT_DST: begin
        cnt_addr    = chosen_r;
        dst_cnt_nxt = dst_val;
        if (dst_val == urnpm_pkg::CNT_MAX) begin
          res_nxt.status = urnpm_pkg::STAT_SAT;
          state_nxt      = urnpm_pkg::S_DONE;
        end else begin
          state_nxt = urnpm_pkg::S_DEC_SRC;
        end
      end

      urnpm_pkg::S_DEC_SRC: begin
        alu_op               = urnpm_pkg::ALU_SUB;
        alu_a                = urnpm_pkg::ALU_W'(src_cnt_r);
        alu_b                = urnpm_pkg::ALU_W'(1);
        cnt_we               = 1'b1;
        src_cnt_nxt          = alu_y[CB-1:0];
        res_nxt.source_count = urnpm_pkg::fit_cnt(alu_y[CB-1:0]);
        state_nxt            = urnpm_pkg::S_INC_DST;
      end

      urnpm_pkg::S_INC_DST: begin
        alu_op                    = urnpm_pkg::ALU_ADD;
        alu_a                     = urnpm_pkg::ALU_W'(dst_cnt_r);
        alu_b                     = urnpm_pkg::ALU_W'(1);
        cnt_addr                  = chosen_r;
        cnt_we                    = 1'b1;
        cnt_vld_nxt[chosen_r]     = 1'b1;
        res_nxt.moved             = 1'b1;
        res_nxt.destination       = urnpm_pkg::NODE_W'(chosen_r);
        res_nxt.destination_count = urnpm_pkg::fit_cnt(alu_y[CB-1:0]);
        state_nxt                 = urnpm_pkg::S_DONE;
      end

      urnpm_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = urnpm_pkg::S_IDLE;
        end
      end

      default: state_nxt = urnpm_pkg::S_IDLE;
    endcase
  end

endmodule

[design/urn_particle_move_on_graph_unit.sv]
// top level of the urn particle move on graph unit: config register,
// output register, command sequencer; depends on urnpm_pkg, urnpm_ctrl
// and urn_particle_move_on_graph_unit_macros.svh
//
//   port group  | direction | contents
//   in_*        | slave     | one command word: kind in tuser, node/row/pick in tdata
//   out_*       | master    | one result word per command
//   cfg_*       | apb slave | node_count register at byte address 0
//
// a node out of range is rejected before any ram read; write row, read and an empty
// source end once the source count is read, add after it is updated, and a move with
// no neighbor once the n row bits are counted (n nodes in use); a move counts neighbors,
// takes the 31 pick bits through the shared subtractor, selects the chosen node and then
// updates both counts; a self loop ends at selection, a full destination at its read
// the rams carry per-entry valid flops, so they need no clearing at reset; in_tready is low
// while a word is in work, and a result waiting in the output register lets the
// sequencer take the next word
`timescale 1ns / 1ps
`include "urn_particle_move_on_graph_unit_macros.svh"

module urn_particle_move_on_graph_unit (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [5:0] node, [69:6] row_bits, [100:70] random_pick, [103:101] zero
  input  logic [103:0]                  in_tdata,
  // [1:0] command
  input  logic [1:0]                    in_tuser,

  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [2:0] status, [3] moved, [9:4] destination, [25:10] source_count,
  // [41:26] destination_count, [47:42] zero
  output logic [47:0]                   out_tdata,

  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [urnpm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [urnpm_pkg::CFG_W-1:0] node_count_r;
  logic [urnpm_pkg::CFG_W-1:0] n_eff;
  logic                        reg_sel;
  logic                        cfg_wr;

  urnpm_pkg::cmd_t cmd;
  urnpm_pkg::res_t res;
  logic            res_valid;
  logic            res_ready;

  urnpm_pkg::res_t out_r;
  logic            out_valid_r;

  // apb register, word-decoded
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[urnpm_pkg::CFG_AW-1:2] == urnpm_pkg::REG_NODE_COUNT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_sel ? 32'(node_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= urnpm_pkg::NODE_COUNT_RST;
    end else if (cfg_wr && reg_sel) begin
      node_count_r <= cfg_pwdata[urnpm_pkg::CFG_W-1:0];
    end
  end

  // nodes in use, zero acts as one, clamp at the array size
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = urnpm_pkg::CFG_W'(1);
    end else if (node_count_r > urnpm_pkg::CFG_W'(urnpm_pkg::MAX_NODES)) begin
      n_eff = urnpm_pkg::CFG_W'(urnpm_pkg::MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  // input word unpack
  assign cmd.command     = in_tuser;
  assign cmd.node        = in_tdata[5:0];
  assign cmd.row_bits    = in_tdata[69:6];
  assign cmd.random_pick = in_tdata[100:70];

  urnpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .n_eff     (n_eff),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r.destination_count, out_r.source_count,
                       out_r.destination, out_r.moved, out_r.status};

  // a taken word keeps the sequencer busy for at least the next cycle
  `URNPM_AST_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // a move is only reported with ok status
  `URNPM_AST_IMPL(a_moved_ok, clk, rst_n, out_valid_r && out_r.moved,
    out_r.status == urnpm_pkg::STAT_OK)

  // no move, no destination fields
  `URNPM_AST_IMPL(a_idle_dest, clk, rst_n, out_valid_r && !out_r.moved,
    out_r.destination == '0 && out_r.destination_count == '0)

  // rejected node reports a zero count
  `URNPM_AST_IMPL(a_range_zero, clk, rst_n,
    out_valid_r && out_r.status == urnpm_pkg::STAT_RANGE, out_r.source_count == '0)

endmodule
